[hdl/owbm_pkg.sv]
package owbm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int DUR_W         = 10;
  localparam int SLOT_W        = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 16;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_SLOT_START    = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_READ_SAMPLE   = 3'd5,
    REG_READ_TAIL     = 3'd6,
    REG_RECOVERY      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0]  reset_low_ticks;
    logic [DUR_W-1:0]  presence_wait_ticks;
    logic [DUR_W-1:0]  reset_tail_ticks;
    logic [SLOT_W-1:0] slot_start_ticks;
    logic [DUR_W-1:0]  write_hold_ticks;
    logic [DUR_W-1:0]  read_sample_ticks;
    logic [DUR_W-1:0]  read_tail_ticks;
    logic [SLOT_W-1:0] recovery_ticks;
  } cfg_t;

  typedef struct packed {
    logic                     start_req;
    logic [1:0]               operation;
    logic [BITS_PER_BYTE-1:0] write_data;
    logic                     line_in;
  } item_t;

  typedef struct packed {
    logic                     line_low;
    logic                     busy_res;
    logic                     done_res;
    logic                     presence;
    logic [BITS_PER_BYTE-1:0] read_data;
  } res_t;

endpackage

[hdl/one_wire_bus_master.sv]
// A word taken on in_ passes the input register and then the output register before it appears on out_.
// Throughput: one input word per cycle while out_tready stays high.
// Every input word is one bus tick; the tick logic sits between the input
// register and the output register.
// Reset (rst_n low, synchronous): bus idle, flags and read byte cleared,
// timing registers back to their defaults.
module one_wire_bus_master
  import owbm_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // start_req, operation[1:0], write_data[7:0], line_in
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // line_low, busy_res, done_res, presence, read_data[7:0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DUR_W-1:0]       cfg_data
);

  logic                   in_vld_r, in_vld_nxt;
  logic [IN_TDATA_W-1:0]  in_data_r;
  logic                   out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   step;
  item_t                  item;
  res_t                   res;
  cfg_t                   cfg;

  assign step       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || step;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign item.start_req  = in_data_r[0];
  assign item.operation  = in_data_r[2:1];
  assign item.write_data = in_data_r[10:3];
  assign item.line_in    = in_data_r[11];

  assign in_vld_nxt  = (in_tvalid && in_tready) || (in_vld_r && !step);
  assign out_vld_nxt = step || (out_vld_r && !out_tready);

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owbm_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
    if (step) begin
      out_data_r <= {4'b0000, res.read_data, res.presence, res.done_res,
                     res.busy_res, res.line_low};
    end
  end

endmodule

[hdl/owbm_cfg.sv]
module owbm_cfg
  import owbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RESET_LOW:     cfg_nxt.reset_low_ticks     = cfg_data;
        REG_PRESENCE_WAIT: cfg_nxt.presence_wait_ticks = cfg_data;
        REG_RESET_TAIL:    cfg_nxt.reset_tail_ticks    = cfg_data;
        REG_SLOT_START:    cfg_nxt.slot_start_ticks    = cfg_data[SLOT_W-1:0];
        REG_WRITE_HOLD:    cfg_nxt.write_hold_ticks    = cfg_data;
        REG_READ_SAMPLE:   cfg_nxt.read_sample_ticks   = cfg_data;
        REG_READ_TAIL:     cfg_nxt.read_tail_ticks     = cfg_data;
        REG_RECOVERY:      cfg_nxt.recovery_ticks      = cfg_data[SLOT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= DUR_W'(490);
      cfg_r.presence_wait_ticks <= DUR_W'(44);
      cfg_r.reset_tail_ticks    <= DUR_W'(89);
      cfg_r.slot_start_ticks    <= SLOT_W'(1);
      cfg_r.write_hold_ticks    <= DUR_W'(89);
      cfg_r.read_sample_ticks   <= DUR_W'(18);
      cfg_r.read_tail_ticks     <= DUR_W'(89);
      cfg_r.recovery_ticks      <= SLOT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[hdl/owbm_core.sv]
module owbm_core
  import owbm_pkg::*;
#(
  parameter int COUNT_WIDTH = 10
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  localparam int CMP_W  = ((COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W) + 1;
  localparam int BIT_W  = $clog2(BITS_PER_BYTE);

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_WAIT   = 4'd2,
    PH_RST_TAIL   = 4'd3,
    PH_SLOT_START = 4'd4,
    PH_W_HOLD     = 4'd5,
    PH_R_WAIT     = 4'd6,
    PH_R_TAIL     = 4'd7,
    PH_RECOV      = 4'd8
  } phase_t;

  phase_t                   phase_r, phase_nxt, ph;
  logic [COUNT_WIDTH-1:0]   cnt_r, cnt_nxt, cnt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [BITS_PER_BYTE-1:0] shift_r, shift_nxt;
  op_t                      op_r, op_nxt;
  logic                     pres_r, pres_nxt;
  logic [BITS_PER_BYTE-1:0] last_r, last_nxt;
  logic [DUR_W-1:0]         dur_raw;
  logic [CMP_W-1:0]         dur;
  logic [CMP_W-1:0]         cnt_inc;
  logic                     phase_end;
  logic                     low;
  logic                     done;

  always_comb begin
    ph        = phase_r;
    cnt       = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    op_nxt    = op_r;
    pres_nxt  = pres_r;
    last_nxt  = last_r;
    low       = 1'b0;
    done      = 1'b0;

    if (phase_r == PH_IDLE && item.start_req && op_t'(item.operation) != OP_NONE) begin
      op_nxt  = op_t'(item.operation);
      cnt     = '0;
      bit_nxt = '0;
      if (op_t'(item.operation) == OP_RESET) begin
        ph = PH_RST_LOW;
      end else begin
        ph        = PH_SLOT_START;
        shift_nxt = (op_t'(item.operation) == OP_WRITE) ? item.write_data : '0;
      end
    end

    unique case (ph)
      PH_RST_LOW:    dur_raw = cfg.reset_low_ticks;
      PH_RST_WAIT:   dur_raw = cfg.presence_wait_ticks;
      PH_RST_TAIL:   dur_raw = cfg.reset_tail_ticks;
      PH_SLOT_START: dur_raw = DUR_W'(cfg.slot_start_ticks);
      PH_W_HOLD:     dur_raw = cfg.write_hold_ticks;
      PH_R_WAIT:     dur_raw = cfg.read_sample_ticks;
      PH_R_TAIL:     dur_raw = cfg.read_tail_ticks;
      default:       dur_raw = DUR_W'(cfg.recovery_ticks);
    endcase
    dur       = (dur_raw == '0) ? CMP_W'(1) : CMP_W'(dur_raw);
    cnt_inc   = CMP_W'(cnt) + CMP_W'(1);
    phase_end = (cnt_inc >= dur) || (cnt == '1);

    phase_nxt = ph;
    cnt_nxt   = cnt;

    unique case (ph)
      PH_IDLE: begin
      end
      PH_RST_LOW, PH_SLOT_START, PH_W_HOLD, PH_RST_WAIT, PH_RST_TAIL,
      PH_R_WAIT, PH_R_TAIL, PH_RECOV: begin
        if (ph == PH_RST_LOW || ph == PH_SLOT_START) begin
          low = 1'b1;
        end else if (ph == PH_W_HOLD) begin
          low = ~shift_nxt[0];
        end
        if (phase_end) begin
          cnt_nxt = '0;
          unique case (ph)
            PH_RST_LOW: phase_nxt = PH_RST_WAIT;
            PH_RST_WAIT: begin
              pres_nxt  = ~item.line_in;
              phase_nxt = PH_RST_TAIL;
            end
            PH_RST_TAIL: begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
            PH_SLOT_START: phase_nxt = (op_nxt == OP_WRITE) ? PH_W_HOLD : PH_R_WAIT;
            PH_W_HOLD: begin
              shift_nxt = {1'b0, shift_nxt[BITS_PER_BYTE-1:1]};
              phase_nxt = PH_RECOV;
            end
            PH_R_WAIT: begin
              shift_nxt = {item.line_in, shift_nxt[BITS_PER_BYTE-1:1]};
              phase_nxt = PH_R_TAIL;
            end
            PH_R_TAIL: phase_nxt = PH_RECOV;
            default: begin
              if (bit_nxt == BIT_W'(BITS_PER_BYTE - 1)) begin
                if (op_nxt == OP_READ) begin
                  last_nxt = shift_nxt;
                end
                phase_nxt = PH_IDLE;
                done      = 1'b1;
              end else begin
                bit_nxt   = bit_nxt + BIT_W'(1);
                phase_nxt = PH_SLOT_START;
              end
            end
          endcase
        end else begin
          cnt_nxt = cnt + COUNT_WIDTH'(1);
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    res.line_low  = low;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      op_r    <= OP_RESET;
      pres_r  <= 1'b0;
      last_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      op_r    <= op_nxt;
      pres_r  <= pres_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

[verif/one_wire_bus_master_tb.sv]
module one_wire_bus_master_tb;
  import owbm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int ROUNDS      = 2;
  localparam int ROUND_TICKS = 100;

  typedef enum logic [3:0] {
    BP_IDLE,
    BP_RST_LOW,
    BP_RST_WAIT,
    BP_RST_TAIL,
    BP_SLOT_OPEN,
    BP_HOLD,
    BP_SAMPLE_WAIT,
    BP_READ_TAIL,
    BP_RECOVER
  } bus_phase_t;

  typedef enum logic [1:0] {
    LINE_LOW,
    LINE_HIGH,
    LINE_RANDOM
  } line_drive_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // start_req, operation[1:0], write_data[7:0], line_in
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // line_low, busy_res, done_res, presence, read_data[7:0]
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DUR_W-1:0]       cfg_data = '0;

  one_wire_bus_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  bus_phase_t       bp = BP_IDLE;
  int               cnt = 0;
  logic [2:0]       bit_idx = '0;
  logic [7:0]       shift_reg = '0;
  op_t              op_held = OP_RESET;
  logic             presence_seen = 1'b0;
  logic [7:0]       last_byte = '0;
  logic [DUR_W-1:0] timing [8] = '{10'd490, 10'd44, 10'd89, 10'd1, 10'd89, 10'd18, 10'd89, 10'd1};
  logic [DUR_W-1:0] timing_plan [8];

  res_t status_due_q[$];
  int   mismatch_count = 0;
  int   ticks_sent = 0;
  bit   idle_on = 1'b1;
  int   rdy_hold = 0;
  int   quiet = 0;

  function automatic int span_of(input bus_phase_t p);
    reg_idx_t r;
    case (p)
      BP_RST_LOW:     r = REG_RESET_LOW;
      BP_RST_WAIT:    r = REG_PRESENCE_WAIT;
      BP_RST_TAIL:    r = REG_RESET_TAIL;
      BP_SLOT_OPEN:   r = REG_SLOT_START;
      BP_HOLD:        r = REG_WRITE_HOLD;
      BP_SAMPLE_WAIT: r = REG_READ_SAMPLE;
      BP_READ_TAIL:   r = REG_READ_TAIL;
      default:        r = REG_RECOVERY;
    endcase
    return (timing[r] == '0) ? 1 : int'(timing[r]);
  endfunction

  function automatic res_t bus_tick(input logic s, input logic [1:0] op,
                                    input logic [7:0] wd, input logic ln);
    res_t r;
    logic lo;
    logic dn;
    lo = 1'b0;
    dn = 1'b0;
    if (bp == BP_IDLE && s && op != OP_NONE) begin
      op_held = op_t'(op);
      cnt     = 0;
      bit_idx = '0;
      if (op == OP_RESET) begin
        bp = BP_RST_LOW;
      end else begin
        bp        = BP_SLOT_OPEN;
        shift_reg = (op == OP_WRITE) ? wd : 8'h00;
      end
    end
    if (bp != BP_IDLE) begin
      case (bp)
        BP_RST_LOW, BP_SLOT_OPEN: lo = 1'b1;
        BP_HOLD:                  lo = ~shift_reg[0];
        default:                  lo = 1'b0;
      endcase
      if (cnt + 1 >= span_of(bp) || cnt >= 1023) begin
        cnt = 0;
        case (bp)
          BP_RST_LOW:   bp = BP_RST_WAIT;
          BP_RST_WAIT: begin
            presence_seen = ~ln;
            bp = BP_RST_TAIL;
          end
          BP_RST_TAIL: begin
            bp = BP_IDLE;
            dn = 1'b1;
          end
          BP_SLOT_OPEN: bp = (op_held == OP_WRITE) ? BP_HOLD : BP_SAMPLE_WAIT;
          BP_HOLD: begin
            shift_reg = shift_reg >> 1;
            bp = BP_RECOVER;
          end
          BP_SAMPLE_WAIT: begin
            shift_reg = {ln, shift_reg[7:1]};
            bp = BP_READ_TAIL;
          end
          BP_READ_TAIL: bp = BP_RECOVER;
          default: begin
            if (bit_idx == 3'd7) begin
              if (op_held == OP_READ) last_byte = shift_reg;
              bp = BP_IDLE;
              dn = 1'b1;
            end else begin
              bit_idx = bit_idx + 3'd1;
              bp = BP_SLOT_OPEN;
            end
          end
        endcase
      end else begin
        cnt = (cnt + 1) & 1023;
      end
    end
    r.line_low  = lo;
    r.busy_res  = (bp != BP_IDLE);
    r.done_res  = dn;
    r.presence  = presence_seen;
    r.read_data = last_byte;
    return r;
  endfunction

  function automatic logic line_level(input line_drive_t mode);
    case (mode)
      LINE_LOW:  return 1'b0;
      LINE_HIGH: return 1'b1;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(input logic s, input logic [1:0] op,
                           input logic [7:0] wd, input logic ln);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, ln, wd, op, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_due_q.push_back(bus_tick(s, op, wd, ln));
    ticks_sent++;
  endtask

  task automatic run_op(input logic [1:0] op, input logic [7:0] wd, input line_drive_t mode);
    send_tick(1'b1, op, wd, line_level(mode));
    while (bp != BP_IDLE)
      send_tick(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)), line_level(mode));
  endtask

  task automatic idle_ticks(input int n);
    repeat (n)
      send_tick(1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timing();
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= timing_plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i == REG_SLOT_START || i == REG_RECOVERY) timing[i] = timing_plan[i] & 10'h03F;
      else timing[i] = timing_plan[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_timing(input int lo, input int hi);
    for (int i = 0; i < 8; i++) begin
      if (i == REG_SLOT_START || i == REG_RECOVERY)
        timing_plan[i] = DUR_W'($urandom_range(lo > 63 ? 63 : lo, hi > 63 ? 63 : hi));
      else
        timing_plan[i] = DUR_W'($urandom_range(lo, hi));
    end
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    logic rdy_next;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.line_low  = out_tdata[0];
        got.busy_res  = out_tdata[1];
        got.done_res  = out_tdata[2];
        got.presence  = out_tdata[3];
        got.read_data = out_tdata[11:4];
        if (status_due_q.size() == 0) begin
          flag_mismatch("unexpected word", 0, int'(out_tdata));
        end else begin
          want = status_due_q.pop_front();
          if (got.line_low != want.line_low) flag_mismatch("line_low", want.line_low, got.line_low);
          if (got.busy_res != want.busy_res) flag_mismatch("busy", want.busy_res, got.busy_res);
          if (got.done_res != want.done_res) flag_mismatch("done", want.done_res, got.done_res);
          if (got.presence != want.presence) flag_mismatch("presence", want.presence, got.presence);
          if (got.read_data != want.read_data)
            flag_mismatch("read_data", want.read_data, got.read_data);
        end
      end
      if (rdy_hold > 0) begin
        rdy_hold--;
        rdy_next = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rdy_hold = $urandom_range(0, 4);
        rdy_next = 1'b0;
      end else begin
        rdy_next = 1'b1;
      end
      out_tready <= rdy_next;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_reset_defaults();
    run_op(OP_RESET, 8'h00, LINE_LOW);
  endtask

  task automatic test_min_timing();
    settle();
    plan_timing(1, 1);
    load_timing();
    run_op(OP_RESET, 8'h00, LINE_LOW);
    run_op(OP_WRITE, 8'hFF, LINE_RANDOM);
    run_op(OP_WRITE, 8'h00, LINE_RANDOM);
    run_op(OP_READ, 8'hFF, LINE_RANDOM);
    run_op(OP_NONE, 8'h5A, LINE_RANDOM);
    run_op(OP_RESET, 8'hFF, LINE_HIGH);
  endtask

  task automatic test_random_timing();
    int   first;
    logic [1:0] op;
    for (int round = 0; round < ROUNDS; round++) begin
      settle();
      if ($urandom_range(0, 3) == 0) plan_timing(1, 8);
      else plan_timing(1, 4);
      load_timing();
      first = ticks_sent;
      while (ticks_sent - first < ROUND_TICKS) begin
        if ($urandom_range(0, 7) == 0) begin
          idle_ticks($urandom_range(1, 3));
        end else begin
          op = ($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
          run_op(op, 8'($urandom_range(0, 255)), LINE_RANDOM);
        end
      end
    end
  endtask

  task automatic test_max_timing();
    settle();
    plan_timing(1023, 1023);
    load_timing();
    run_op(OP_NONE, 8'h00, LINE_RANDOM);
    idle_ticks(4);
  endtask

  task automatic test_streaming();
    settle();
    idle_on = 1'b0;
    plan_timing(1, 3);
    load_timing();
    run_op(OP_RESET, 8'($urandom_range(0, 255)), LINE_RANDOM);
    run_op(OP_WRITE, 8'($urandom_range(0, 255)), LINE_RANDOM);
    run_op(OP_READ, 8'($urandom_range(0, 255)), LINE_RANDOM);
    idle_ticks(3);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_min_timing();
    test_random_timing();
    test_max_timing();
    test_streaming();
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && status_due_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
